// File: src/rmj_pkg.sv
// Package for the radar measurement Jacobian block.
// Holds the default widths, the threshold reset value and the flag word that
// travels with each state through the pipeline. It has no dependencies.
`default_nettype none

package rmj_pkg;

    localparam int RMJ_FRAC_BITS = 16;
    localparam int RMJ_WORD_BITS = 32;
    localparam int RMJ_THR_BITS  = 32;

    localparam logic [RMJ_THR_BITS-1:0] RMJ_MIN_RANGE_RESET = 32'd429497;

    // Number of nonzero Jacobian entries that are computed by a divider.
    localparam int RMJ_LANES = 6;

    // Lane numbers of the dividers.
    localparam int RMJ_LANE_RANGE_PX   = 0;
    localparam int RMJ_LANE_RANGE_PY   = 1;
    localparam int RMJ_LANE_BEARING_PX = 2;
    localparam int RMJ_LANE_BEARING_PY = 3;
    localparam int RMJ_LANE_RATE_PX    = 4;
    localparam int RMJ_LANE_RATE_PY    = 5;

    // Per-word control flags carried alongside the data.
    typedef struct packed {
        logic computed;
        logic sp;
        logic sq;
        logic dneg;
    } rmj_flags_t;

    localparam int RMJ_FLAG_W = $bits(rmj_flags_t);

endpackage

`default_nettype wire

// File: src/rmj_sqrt_cell.sv
// One digit step of the pipelined integer square root.
// Each cell settles one root bit and hands its partial root and remainder on.
// Depends on nothing outside this file.
`default_nettype none

module rmj_sqrt_cell #(
    parameter int ROOT_BITS = 48
) (
    input  wire logic                   clk,
    input  wire logic [2*ROOT_BITS-1:0] x_in,
    input  wire logic [ROOT_BITS+1:0]   rem_in,
    input  wire logic [ROOT_BITS-1:0]   root_in,
    output logic      [2*ROOT_BITS-1:0] x_reg,
    output logic      [ROOT_BITS+1:0]   rem_reg,
    output logic      [ROOT_BITS-1:0]   root_reg
);

    localparam int TW = ROOT_BITS + 4;

    logic [TW-1:0]          trial_rem;
    logic [TW-1:0]          trial_sub;
    logic                   take;
    logic [ROOT_BITS+1:0]   rem_next;
    logic [ROOT_BITS-1:0]   root_next;
    logic [2*ROOT_BITS-1:0] x_next;

    always_comb
    begin
        // Bring down the next two radicand bits and try the divisor 4r+1.
        trial_rem = {rem_in, x_in[2*ROOT_BITS-1 -: 2]};
        trial_sub = {2'b00, root_in, 2'b01};
        take      = (trial_rem >= trial_sub);
        if (take)
        begin
            rem_next = (ROOT_BITS+2)'(trial_rem - trial_sub);
        end
        else
        begin
            rem_next = trial_rem[ROOT_BITS+1:0];
        end
        root_next = {root_in[ROOT_BITS-2:0], take};
        x_next    = {x_in[2*ROOT_BITS-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

`default_nettype wire

// File: src/rmj_div_cell.sv
// One restoring step of the pipelined divider.
// Each cell settles one quotient bit and passes remainder, divisor and the
// remaining dividend bits on. Depends on nothing outside this file.
`default_nettype none

module rmj_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int DEN_BITS  = 48
) (
    input  wire logic                 clk,
    input  wire logic [DEN_BITS-1:0]  rem_in,
    input  wire logic [WORD_BITS-1:0] lo_in,
    input  wire logic [WORD_BITS-1:0] quo_in,
    input  wire logic [DEN_BITS-1:0]  den_in,
    input  wire logic                 ovf_in,
    output logic      [DEN_BITS-1:0]  rem_reg,
    output logic      [WORD_BITS-1:0] lo_reg,
    output logic      [WORD_BITS-1:0] quo_reg,
    output logic      [DEN_BITS-1:0]  den_reg,
    output logic                      ovf_reg
);

    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic                ge;
    logic [DEN_BITS-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_in, lo_in[WORD_BITS-1]};
        diff     = shifted - {1'b0, den_in};
        ge       = (shifted >= {1'b0, den_in});
        rem_next = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= {lo_in[WORD_BITS-2:0], 1'b0};
        quo_reg <= {quo_in[WORD_BITS-2:0], ge};
        den_reg <= den_in;
        ovf_reg <= ovf_in;
    end

endmodule

`default_nettype wire

// File: src/rmj_div.sv
// Pipelined divider: an overflow check stage followed by a row of
// restoring cells, one quotient bit per cell. Depends on rmj_div_cell.
`default_nettype none

module rmj_div #(
    parameter int WORD_BITS   = 32,
    parameter int NUM_HI_BITS = 32,
    parameter int DEN_BITS    = 48
) (
    input  wire logic                   clk,
    input  wire logic [NUM_HI_BITS-1:0] num_hi,
    input  wire logic [WORD_BITS-1:0]   num_lo,
    input  wire logic [DEN_BITS-1:0]    den,
    output logic      [WORD_BITS-1:0]   quo,
    output logic                        ovf
);

    localparam int CW = (NUM_HI_BITS > DEN_BITS) ? NUM_HI_BITS : DEN_BITS;

    logic [DEN_BITS-1:0]  c_rem [WORD_BITS+1];
    logic [WORD_BITS-1:0] c_lo  [WORD_BITS+1];
    logic [WORD_BITS-1:0] c_quo [WORD_BITS+1];
    logic [DEN_BITS-1:0]  c_den [WORD_BITS+1];
    logic                 c_ovf [WORD_BITS+1];

    // If the upper dividend part already reaches the divisor, the quotient
    // does not fit in a word and the cells' result is meaningless.
    always_ff @(posedge clk)
    begin
        c_rem[0] <= DEN_BITS'(num_hi);
        c_lo[0]  <= num_lo;
        c_quo[0] <= '0;
        c_den[0] <= den;
        c_ovf[0] <= (CW'(num_hi) >= CW'(den));
    end

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_cell
        rmj_div_cell #(
            .WORD_BITS (WORD_BITS),
            .DEN_BITS  (DEN_BITS)
        ) u_cell (
            .clk     (clk),
            .rem_in  (c_rem[k]),
            .lo_in   (c_lo[k]),
            .quo_in  (c_quo[k]),
            .den_in  (c_den[k]),
            .ovf_in  (c_ovf[k]),
            .rem_reg (c_rem[k+1]),
            .lo_reg  (c_lo[k+1]),
            .quo_reg (c_quo[k+1]),
            .den_reg (c_den[k+1]),
            .ovf_reg (c_ovf[k+1])
        );
    end

    assign quo = c_quo[WORD_BITS];
    assign ovf = c_ovf[WORD_BITS];

endmodule

`default_nettype wire

// File: src/radar_measurement_jacobian.sv
// Top level of the radar measurement Jacobian for a constant-velocity state.
// Depends on rmj_pkg, rmj_sqrt_cell and rmj_div (which uses rmj_div_cell).
//
// Channel   Direction  Handshake                 Payload
// state     in         start, busy               pos_x, pos_y, vel_x, vel_y
// config    in         cfg_valid, cfg_ready      min_range_squared
// result    out        done (one-cycle strobe)   eight entries, computed, saturated
//
// One state word is taken in every cycle; busy stays low. The depth of the
// pipeline is set by the row of square-root cells (one per root bit) followed
// by the rows of divider cells (one per quotient bit). The receiver cannot
// stall. Reset clears the valid pipeline and loads the threshold default.
`default_nettype none

module radar_measurement_jacobian
    import rmj_pkg::*;
#(
    parameter int FRAC_BITS = RMJ_FRAC_BITS,
    parameter int WORD_BITS = RMJ_WORD_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [WORD_BITS-1:0] pos_x,
    input  wire logic signed [WORD_BITS-1:0] pos_y,
    input  wire logic signed [WORD_BITS-1:0] vel_x,
    input  wire logic signed [WORD_BITS-1:0] vel_y,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [RMJ_THR_BITS-1:0]     min_range_squared,
    output logic                             done,
    output logic signed [WORD_BITS-1:0]      range_by_px,
    output logic signed [WORD_BITS-1:0]      range_by_py,
    output logic signed [WORD_BITS-1:0]      bearing_by_px,
    output logic signed [WORD_BITS-1:0]      bearing_by_py,
    output logic signed [WORD_BITS-1:0]      rate_by_px,
    output logic signed [WORD_BITS-1:0]      rate_by_py,
    output logic signed [WORD_BITS-1:0]      rate_by_vx,
    output logic signed [WORD_BITS-1:0]      rate_by_vy,
    output logic                             computed,
    output logic                             saturated
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int W2  = 2 * W;
    localparam int W3  = 3 * W;
    localparam int RW  = W + F;
    localparam int XW  = 2 * RW;
    localparam int F2  = 2 * F;
    localparam int TDW = W3 + F;
    localparam int NRW = W + F2;
    localparam int NTW = W3 + F2;
    localparam int SW  = RMJ_FLAG_W + 10 * W;
    localparam int VN  = RW + W + 7;

    // Threshold register
    logic [RMJ_THR_BITS-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= RMJ_MIN_RANGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= min_range_squared;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Sign and magnitude of the inputs
    logic         px_neg, py_neg, vx_neg, vy_neg;
    logic [W-1:0] px_mag, py_mag, vx_mag, vy_mag;

    always_comb
    begin
        px_neg = pos_x[W-1];
        py_neg = pos_y[W-1];
        vx_neg = vel_x[W-1];
        vy_neg = vel_y[W-1];
        px_mag = px_neg ? (~$unsigned(pos_x) + 1'b1) : $unsigned(pos_x);
        py_mag = py_neg ? (~$unsigned(pos_y) + 1'b1) : $unsigned(pos_y);
        vx_mag = vx_neg ? (~$unsigned(vel_x) + 1'b1) : $unsigned(vel_x);
        vy_mag = vy_neg ? (~$unsigned(vel_y) + 1'b1) : $unsigned(vel_y);
    end

    // Stage A1: products
    logic          a1_sp_reg, a1_sq_reg, a1_su_reg, a1_sv_reg;
    logic [W-1:0]  a1_mp_reg, a1_mq_reg;
    logic [W2-1:0] a1_pp_reg, a1_qq_reg, a1_uq_reg, a1_vp_reg;

    always_ff @(posedge clk)
    begin
        a1_sp_reg <= px_neg;
        a1_sq_reg <= py_neg;
        a1_su_reg <= vx_neg;
        a1_sv_reg <= vy_neg;
        a1_mp_reg <= px_mag;
        a1_mq_reg <= py_mag;
        a1_pp_reg <= W2'(px_mag) * W2'(px_mag);
        a1_qq_reg <= W2'(py_mag) * W2'(py_mag);
        a1_uq_reg <= W2'(vx_mag) * W2'(py_mag);
        a1_vp_reg <= W2'(vy_mag) * W2'(px_mag);
    end

    // Stage A2: squared range, cross term as sign and magnitude, threshold
    logic [W2-1:0] s_next;
    logic [W2-1:0] dm_next;
    logic          dneg_next;
    logic          n1, n2;

    always_comb
    begin
        s_next = a1_pp_reg + a1_qq_reg;
        n1     = a1_su_reg ^ a1_sq_reg;
        n2     = ~(a1_sv_reg ^ a1_sp_reg);
        if (n1 == n2)
        begin
            dm_next   = a1_uq_reg + a1_vp_reg;
            dneg_next = n1;
        end
        else if (a1_uq_reg >= a1_vp_reg)
        begin
            dm_next   = a1_uq_reg - a1_vp_reg;
            dneg_next = n1;
        end
        else
        begin
            dm_next   = a1_vp_reg - a1_uq_reg;
            dneg_next = n2;
        end
    end

    rmj_flags_t    a2_fl_reg;
    logic [W-1:0]  a2_mp_reg, a2_mq_reg;
    logic [W2-1:0] a2_s_reg, a2_dm_reg;

    always_ff @(posedge clk)
    begin
        a2_fl_reg.computed <= (s_next > W2'(thr_reg));
        a2_fl_reg.sp       <= a1_sp_reg;
        a2_fl_reg.sq       <= a1_sq_reg;
        a2_fl_reg.dneg     <= dneg_next;
        a2_mp_reg          <= a1_mp_reg;
        a2_mq_reg          <= a1_mq_reg;
        a2_s_reg           <= s_next;
        a2_dm_reg          <= dm_next;
    end

    // Stage A3: partial products of the rate numerators
    rmj_flags_t    a3_fl_reg;
    logic [W-1:0]  a3_mp_reg, a3_mq_reg;
    logic [W2-1:0] a3_s_reg;
    logic [W2-1:0] a3_qd_lo_reg, a3_qd_hi_reg, a3_pd_lo_reg, a3_pd_hi_reg;

    always_ff @(posedge clk)
    begin
        a3_fl_reg    <= a2_fl_reg;
        a3_mp_reg    <= a2_mp_reg;
        a3_mq_reg    <= a2_mq_reg;
        a3_s_reg     <= a2_s_reg;
        a3_qd_lo_reg <= W2'(a2_mq_reg) * W2'(a2_dm_reg[W-1:0]);
        a3_qd_hi_reg <= W2'(a2_mq_reg) * W2'(a2_dm_reg[W2-1:W]);
        a3_pd_lo_reg <= W2'(a2_mp_reg) * W2'(a2_dm_reg[W-1:0]);
        a3_pd_hi_reg <= W2'(a2_mp_reg) * W2'(a2_dm_reg[W2-1:W]);
    end

    // Stage A4: rate numerators summed
    rmj_flags_t    a4_fl_reg;
    logic [W-1:0]  a4_mp_reg, a4_mq_reg;
    logic [W2-1:0] a4_s_reg;
    logic [W3-1:0] a4_qd_reg, a4_pd_reg;

    always_ff @(posedge clk)
    begin
        a4_fl_reg <= a3_fl_reg;
        a4_mp_reg <= a3_mp_reg;
        a4_mq_reg <= a3_mq_reg;
        a4_s_reg  <= a3_s_reg;
        a4_qd_reg <= {a3_qd_hi_reg, {W{1'b0}}} + W3'(a3_qd_lo_reg);
        a4_pd_reg <= {a3_pd_hi_reg, {W{1'b0}}} + W3'(a3_pd_lo_reg);
    end

    // Square-root row; the other data rides along in a shift line.
    logic [XW-1:0]   sq_x    [RW+1];
    logic [RW+1:0]   sq_rem  [RW+1];
    logic [RW-1:0]   sq_root [RW+1];
    logic [SW-1:0]   side_reg [RW];

    assign sq_x[0]    = {a4_s_reg, {F2{1'b0}}};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        rmj_sqrt_cell #(
            .ROOT_BITS (RW)
        ) u_cell (
            .clk      (clk),
            .x_in     (sq_x[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .x_reg    (sq_x[k+1]),
            .rem_reg  (sq_rem[k+1]),
            .root_reg (sq_root[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= {a4_fl_reg, a4_mq_reg, a4_mp_reg, a4_s_reg, a4_pd_reg, a4_qd_reg};
        for (int k = 1; k < RW; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    rmj_flags_t    t_fl;
    logic [W-1:0]  t_mp, t_mq;
    logic [W2-1:0] t_s;
    logic [W3-1:0] t_qd, t_pd;

    assign {t_fl, t_mq, t_mp, t_s, t_pd, t_qd} = side_reg[RW-1];

    // Stage B1: partial products of the rate divisor S * rho
    rmj_flags_t    b1_fl_reg;
    logic [W-1:0]  b1_mp_reg, b1_mq_reg;
    logic [W2-1:0] b1_s_reg;
    logic [W3-1:0] b1_qd_reg, b1_pd_reg;
    logic [RW-1:0] b1_r_reg;
    logic [W2-1:0] b1_pll_reg, b1_phl_reg;
    logic [RW-1:0] b1_plh_reg, b1_phh_reg;

    always_ff @(posedge clk)
    begin
        b1_fl_reg  <= t_fl;
        b1_mp_reg  <= t_mp;
        b1_mq_reg  <= t_mq;
        b1_s_reg   <= t_s;
        b1_qd_reg  <= t_qd;
        b1_pd_reg  <= t_pd;
        b1_r_reg   <= sq_root[RW];
        b1_pll_reg <= W2'(t_s[W-1:0]) * W2'(sq_root[RW][W-1:0]);
        b1_phl_reg <= W2'(t_s[W2-1:W]) * W2'(sq_root[RW][W-1:0]);
        b1_plh_reg <= RW'(t_s[W-1:0]) * RW'(sq_root[RW][RW-1:W]);
        b1_phh_reg <= RW'(t_s[W2-1:W]) * RW'(sq_root[RW][RW-1:W]);
    end

    // Stage B2: rate divisor summed
    rmj_flags_t     b2_fl_reg;
    logic [W-1:0]   b2_mp_reg, b2_mq_reg;
    logic [W2-1:0]  b2_s_reg;
    logic [W3-1:0]  b2_qd_reg, b2_pd_reg;
    logic [RW-1:0]  b2_r_reg;
    logic [TDW-1:0] b2_den_reg;

    always_ff @(posedge clk)
    begin
        b2_fl_reg  <= b1_fl_reg;
        b2_mp_reg  <= b1_mp_reg;
        b2_mq_reg  <= b1_mq_reg;
        b2_s_reg   <= b1_s_reg;
        b2_qd_reg  <= b1_qd_reg;
        b2_pd_reg  <= b1_pd_reg;
        b2_r_reg   <= b1_r_reg;
        b2_den_reg <= {b1_phh_reg, {W2{1'b0}}}
                    + TDW'({b1_plh_reg, {W{1'b0}}})
                    + TDW'({b1_phl_reg, {W{1'b0}}})
                    + TDW'(b1_pll_reg);
    end

    // Dividends: magnitude scaled by 2^(2F), split into the part that
    // seeds the remainder and the word that the cells shift in.
    logic [NRW-1:0] np_full, nq_full;
    logic [NTW-1:0] nqd_full, npd_full;

    assign np_full  = {b2_mp_reg, {F2{1'b0}}};
    assign nq_full  = {b2_mq_reg, {F2{1'b0}}};
    assign nqd_full = {b2_qd_reg, {F2{1'b0}}};
    assign npd_full = {b2_pd_reg, {F2{1'b0}}};

    logic [W-1:0] quo [RMJ_LANES];
    logic         ovf [RMJ_LANES];

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(F2), .DEN_BITS(RW)) u_div_range_px (
        .clk    (clk),
        .num_hi (np_full[NRW-1:W]),
        .num_lo (np_full[W-1:0]),
        .den    (b2_r_reg),
        .quo    (quo[RMJ_LANE_RANGE_PX]),
        .ovf    (ovf[RMJ_LANE_RANGE_PX])
    );

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(F2), .DEN_BITS(RW)) u_div_range_py (
        .clk    (clk),
        .num_hi (nq_full[NRW-1:W]),
        .num_lo (nq_full[W-1:0]),
        .den    (b2_r_reg),
        .quo    (quo[RMJ_LANE_RANGE_PY]),
        .ovf    (ovf[RMJ_LANE_RANGE_PY])
    );

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(F2), .DEN_BITS(W2)) u_div_bearing_px (
        .clk    (clk),
        .num_hi (nq_full[NRW-1:W]),
        .num_lo (nq_full[W-1:0]),
        .den    (b2_s_reg),
        .quo    (quo[RMJ_LANE_BEARING_PX]),
        .ovf    (ovf[RMJ_LANE_BEARING_PX])
    );

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(F2), .DEN_BITS(W2)) u_div_bearing_py (
        .clk    (clk),
        .num_hi (np_full[NRW-1:W]),
        .num_lo (np_full[W-1:0]),
        .den    (b2_s_reg),
        .quo    (quo[RMJ_LANE_BEARING_PY]),
        .ovf    (ovf[RMJ_LANE_BEARING_PY])
    );

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(W2 + F2), .DEN_BITS(TDW)) u_div_rate_px (
        .clk    (clk),
        .num_hi (nqd_full[NTW-1:W]),
        .num_lo (nqd_full[W-1:0]),
        .den    (b2_den_reg),
        .quo    (quo[RMJ_LANE_RATE_PX]),
        .ovf    (ovf[RMJ_LANE_RATE_PX])
    );

    rmj_div #(.WORD_BITS(W), .NUM_HI_BITS(W2 + F2), .DEN_BITS(TDW)) u_div_rate_py (
        .clk    (clk),
        .num_hi (npd_full[NTW-1:W]),
        .num_lo (npd_full[W-1:0]),
        .den    (b2_den_reg),
        .quo    (quo[RMJ_LANE_RATE_PY]),
        .ovf    (ovf[RMJ_LANE_RATE_PY])
    );

    // Flags follow the divider rows.
    rmj_flags_t fl_reg [W+1];

    always_ff @(posedge clk)
    begin
        fl_reg[0] <= b2_fl_reg;
        for (int k = 1; k <= W; k++)
        begin
            fl_reg[k] <= fl_reg[k-1];
        end
    end

    // Sign, clamp and zeroing of each lane
    rmj_flags_t   fo;
    logic         lane_neg  [RMJ_LANES];
    logic [W-1:0] lane_lim  [RMJ_LANES];
    logic         lane_sat  [RMJ_LANES];
    logic [W-1:0] lane_mag  [RMJ_LANES];
    logic [W-1:0] lane_next [RMJ_LANES];
    logic         sat_next;

    always_comb
    begin
        fo = fl_reg[W];
        lane_neg[RMJ_LANE_RANGE_PX]   = fo.sp;
        lane_neg[RMJ_LANE_RANGE_PY]   = fo.sq;
        lane_neg[RMJ_LANE_BEARING_PX] = ~fo.sq;
        lane_neg[RMJ_LANE_BEARING_PY] = fo.sp;
        lane_neg[RMJ_LANE_RATE_PX]    = fo.sq ^ fo.dneg;
        lane_neg[RMJ_LANE_RATE_PY]    = ~(fo.sp ^ fo.dneg);
        sat_next = 1'b0;
        for (int i = 0; i < RMJ_LANES; i++)
        begin
            // A negative entry may reach one step further than a positive one.
            lane_lim[i] = lane_neg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            lane_sat[i] = ovf[i] || (quo[i] > lane_lim[i]);
            lane_mag[i] = lane_sat[i] ? lane_lim[i] : quo[i];
            if (!fo.computed)
            begin
                lane_next[i] = '0;
            end
            else if (lane_neg[i])
            begin
                lane_next[i] = ~lane_mag[i] + 1'b1;
            end
            else
            begin
                lane_next[i] = lane_mag[i];
            end
            sat_next = sat_next | (lane_sat[i] & fo.computed);
        end
    end

    logic [W-1:0] lane_reg [RMJ_LANES];
    logic         computed_reg;
    logic         saturated_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RMJ_LANES; i++)
        begin
            lane_reg[i] <= lane_next[i];
        end
        computed_reg  <= fo.computed;
        saturated_reg <= sat_next;
    end

    // Valid pipeline and result strobe
    logic [VN-1:0] vld_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VN-2:0], start && !busy};
            done_reg <= vld_reg[VN-1];
        end
    end

    assign done          = done_reg;
    assign range_by_px   = $signed(lane_reg[RMJ_LANE_RANGE_PX]);
    assign range_by_py   = $signed(lane_reg[RMJ_LANE_RANGE_PY]);
    assign bearing_by_px = $signed(lane_reg[RMJ_LANE_BEARING_PX]);
    assign bearing_by_py = $signed(lane_reg[RMJ_LANE_BEARING_PY]);
    assign rate_by_px    = $signed(lane_reg[RMJ_LANE_RATE_PX]);
    assign rate_by_py    = $signed(lane_reg[RMJ_LANE_RATE_PY]);
    assign rate_by_vx    = $signed(lane_reg[RMJ_LANE_RANGE_PX]);
    assign rate_by_vy    = $signed(lane_reg[RMJ_LANE_RANGE_PY]);
    assign computed      = computed_reg;
    assign saturated     = saturated_reg;

`ifndef SYNTHESIS
    // Every accepted word yields its result after the fixed pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(VN+1) done)
        else $error("result strobe missing after pipeline latency");

    // A word below the range threshold gives an all-zero, unsaturated result.
    a_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !computed) |-> (!saturated && range_by_px == 0 && range_by_py == 0
            && bearing_by_px == 0 && bearing_by_py == 0 && rate_by_px == 0
            && rate_by_py == 0))
        else $error("zeroed result carries nonzero entries or saturation");

    // The strobe is only raised for words that entered the pipeline.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(vld_reg[VN-1]))
        else $error("result strobe without an accepted word");
`endif

endmodule

`default_nettype wire
